[hdl/dltld_pkg.sv]
// Shared types, field widths, request kind codes and defaults for the dark level tracker.
// No dependencies.
`default_nettype none
package dltld_pkg;

   localparam int DATA_W           = 10;
   localparam int COUNT_W          = 16;
   localparam int KIND_W           = 3;
   localparam int NUM_SAMPLES      = 5;
   localparam int SUM_W            = 13;
   localparam int GROUP_SIZE_DEF   = 5;
   localparam int RECIP_SHIFT      = 16;

   localparam logic [DATA_W-1:0]  THRESHOLD_RESET = 10'd100;
   localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;

   localparam logic [KIND_W-1:0] KIND_SEED       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_UPDATE     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SINGLE     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_GROUP      = 3'd3;
   localparam logic [KIND_W-1:0] KIND_GROUP_UPD  = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [DATA_W-1:0] sample_a;
      logic [DATA_W-1:0] sample_b;
      logic [DATA_W-1:0] sample_c;
      logic [DATA_W-1:0] sample_d;
      logic [DATA_W-1:0] sample_e;
   } req_type;

   typedef struct packed {
      logic              light_seen;
      logic [DATA_W-1:0] judged_value;
      logic [DATA_W-1:0] dark_mean;
   } rsp_type;

   typedef struct packed {
      logic load_req;
      logic dispatch;
      logic div_start_update;
      logic judge;
      logic apply;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              div_done;
      logic              seen_now;
   } status_type;

endpackage
`default_nettype wire

[hdl/dltld_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned SUM_W / COUNT_W.
// Depends on dltld_pkg.
`default_nettype none
module dltld_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [dltld_pkg::SUM_W-1:0]   dividend,
   input  wire logic [dltld_pkg::COUNT_W-1:0] divisor,
   output logic                               done,
   output logic [dltld_pkg::SUM_W-1:0]        quotient
);
   import dltld_pkg::*;

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [COUNT_W:0]   trial;
   logic [COUNT_W:0]   diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CNT_W'(SUM_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (!diff[COUNT_W]) begin
            rem_in = diff[COUNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[COUNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

[hdl/dltld_datapath.sv]
// Datapath: request and result registers, mean, count, threshold, judge and update arithmetic.
// Depends on dltld_pkg and dltld_div.
`default_nettype none
module dltld_datapath #(
   parameter int GROUP_SIZE = dltld_pkg::GROUP_SIZE_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire dltld_pkg::req_type           req_data,
   input  wire logic                         csr_we,
   input  wire logic [dltld_pkg::DATA_W-1:0] csr_wdata,
   input  wire dltld_pkg::cmd_type           cmd,
   output dltld_pkg::status_type             status,
   output dltld_pkg::rsp_type                rsp_data
);
   import dltld_pkg::*;

   localparam int GROUP_USED = (GROUP_SIZE < NUM_SAMPLES) ? GROUP_SIZE : NUM_SAMPLES;
   localparam int RECIP_W    = RECIP_SHIFT + 1;
   localparam int PROD_W     = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] GROUP_RECIP =
      RECIP_W'((2 ** RECIP_SHIFT + GROUP_USED - 1) / GROUP_USED);

   req_type            req_ff;
   rsp_type            rsp_ff;
   logic [DATA_W-1:0]  thr_ff, thr_in;
   logic [DATA_W-1:0]  mean_ff, mean_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [DATA_W-1:0]  judged_ff, judged_in;
   logic [DATA_W-1:0]  upd_ff, upd_in;
   logic               seen_ff, seen_in;
   logic               neg_ff, neg_in;

   logic [DATA_W-1:0]  samp [NUM_SAMPLES];
   logic [SUM_W-1:0]   sum;
   logic [PROD_W-1:0]  group_prod;
   logic [DATA_W-1:0]  group_mean;
   logic [DATA_W:0]    delta;
   logic [DATA_W-1:0]  abs_delta;
   logic signed [DATA_W+1:0] margin;
   logic               seen_now;
   logic               div_start;
   logic [SUM_W-1:0]   div_dividend;
   logic [COUNT_W-1:0] div_divisor;
   logic               div_done;
   logic [SUM_W-1:0]   div_quotient;
   logic signed [SUM_W+1:0] next_mean;

   always_comb begin
      samp[0] = req_ff.sample_a;
      samp[1] = req_ff.sample_b;
      samp[2] = req_ff.sample_c;
      samp[3] = req_ff.sample_d;
      samp[4] = req_ff.sample_e;
      sum = '0;
      for (int i = 0; i < NUM_SAMPLES; i++) begin
         if (i < GROUP_USED) begin
            sum = sum + SUM_W'(samp[i]);
         end
      end
   end

   // group mean by reciprocal multiply, exact over the whole sum range
   assign group_prod = PROD_W'(sum) * PROD_W'(GROUP_RECIP);
   assign group_mean = group_prod[RECIP_SHIFT +: DATA_W];

   assign delta     = {1'b0, upd_ff} - {1'b0, mean_ff};
   assign abs_delta = delta[DATA_W] ? DATA_W'(-delta) : delta[DATA_W-1:0];
   assign margin    = $signed({2'b00, mean_ff}) - $signed({2'b00, judged_ff});
   assign seen_now  = margin > $signed({2'b00, thr_ff});

   assign div_start    = cmd.div_start_update;
   assign div_dividend = SUM_W'(abs_delta);
   assign div_divisor  = (count_ff == '0) ? COUNT_W'(1) : count_ff;

   dltld_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      if (neg_ff) begin
         next_mean = $signed({5'd0, mean_ff}) - $signed({2'b00, div_quotient});
      end else begin
         next_mean = $signed({5'd0, mean_ff}) + $signed({2'b00, div_quotient});
      end
   end

   always_comb begin
      thr_in    = csr_we ? csr_wdata : thr_ff;
      mean_in   = mean_ff;
      count_in  = count_ff;
      judged_in = judged_ff;
      upd_in    = upd_ff;
      seen_in   = seen_ff;
      neg_in    = neg_ff;
      if (cmd.dispatch) begin
         seen_in   = 1'b0;
         judged_in = '0;
         upd_in    = req_ff.sample_a;
         unique case (req_ff.kind)
            KIND_SEED: begin
               mean_in  = req_ff.sample_a;
               count_in = COUNT_W'(1);
            end
            KIND_SINGLE: begin
               judged_in = req_ff.sample_a;
            end
            KIND_GROUP, KIND_GROUP_UPD: begin
               judged_in = group_mean;
               upd_in    = group_mean;
            end
            default: begin
            end
         endcase
      end
      if (cmd.judge) begin
         seen_in = seen_now;
      end
      if (cmd.div_start_update) begin
         neg_in = delta[DATA_W];
      end
      if (cmd.apply) begin
         priority if (next_mean < 0) begin
            mean_in = '0;
         end else if (next_mean > $signed({5'd0, {DATA_W{1'b1}}})) begin
            mean_in = '1;
         end else begin
            mean_in = next_mean[DATA_W-1:0];
         end
         if (count_ff != COUNT_MAX) begin
            count_in = count_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= THRESHOLD_RESET;
         mean_ff  <= '0;
         count_ff <= '0;
      end else begin
         thr_ff   <= thr_in;
         mean_ff  <= mean_in;
         count_ff <= count_in;
      end
      judged_ff <= judged_in;
      upd_ff    <= upd_in;
      seen_ff   <= seen_in;
      neg_ff    <= neg_in;
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.load_rsp) begin
         rsp_ff.light_seen   <= seen_ff;
         rsp_ff.judged_value <= judged_ff;
         rsp_ff.dark_mean    <= mean_ff;
      end
   end

   assign status.kind     = req_ff.kind;
   assign status.div_done = div_done;
   assign status.seen_now = seen_now;
   assign rsp_data        = rsp_ff;

endmodule
`default_nettype wire

[hdl/dltld_ctrl.sv]
// Controller state machine: sequences decode, judge and update steps; owns handshakes.
// Depends on dltld_pkg.
`default_nettype none
module dltld_ctrl #(
   parameter int GROUP_SIZE = dltld_pkg::GROUP_SIZE_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire dltld_pkg::status_type status,
   output dltld_pkg::cmd_type         cmd
);
   import dltld_pkg::*;

   localparam int LOOP_W = $clog2(GROUP_SIZE + 1);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b000_0001,
      ST_DISPATCH = 7'b000_0010,
      ST_JUDGE    = 7'b000_0100,
      ST_USTART   = 7'b000_1000,
      ST_UDIV     = 7'b001_0000,
      ST_APPLY    = 7'b010_0000,
      ST_FINISH   = 7'b100_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [LOOP_W-1:0] loops_ff, loops_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      loops_in     = loops_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            cmd.dispatch = 1'b1;
            unique case (status.kind)
               KIND_UPDATE: begin
                  loops_in = LOOP_W'(1);
                  state_in = ST_USTART;
               end
               KIND_SINGLE, KIND_GROUP, KIND_GROUP_UPD: state_in = ST_JUDGE;
               default: state_in = ST_FINISH;
            endcase
         end
         ST_JUDGE: begin
            cmd.judge = 1'b1;
            if (status.seen_now || status.kind == KIND_GROUP) begin
               state_in = ST_FINISH;
            end else begin
               loops_in = (status.kind == KIND_SINGLE) ? LOOP_W'(1) : LOOP_W'(GROUP_SIZE);
               state_in = ST_USTART;
            end
         end
         ST_USTART: begin
            cmd.div_start_update = 1'b1;
            state_in             = ST_UDIV;
         end
         ST_UDIV: begin
            if (status.div_done) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            loops_in  = loops_ff - LOOP_W'(1);
            state_in  = (loops_ff == LOOP_W'(1)) ? ST_FINISH : ST_USTART;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         loops_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loops_ff     <= loops_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

[hdl/dark_level_tracker_light_detector.sv]
// Sequence, accept to result valid: seed and unused kinds dispatch, then finish; judge kinds
// dispatch and judge, then finish if light is seen or for a group judge; an update runs one
// step, a single judge one, a group judge and update GROUP_SIZE; steps divide, then apply.
// Throughput: one request at a time; ready again in the cycle the result turns valid, even
// while that result waits; a waiting result holds only the next one at its end.
// Reset (synchronous): mean and count clear, threshold returns to 100, channels go empty.
`default_nettype none
module dark_level_tracker_light_detector #(
   parameter int GROUP_SIZE = dltld_pkg::GROUP_SIZE_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire dltld_pkg::req_type           req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output dltld_pkg::rsp_type                rsp_data,
   input  wire logic                         csr_we,
   input  wire logic [dltld_pkg::DATA_W-1:0] csr_wdata
);
   import dltld_pkg::*;

   cmd_type    cmd;
   status_type status;

   dltld_ctrl #(.GROUP_SIZE(GROUP_SIZE)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dltld_datapath #(.GROUP_SIZE(GROUP_SIZE)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while one is in flight");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !rsp_valid || rsp_ready)
      else $error("pending result overwritten");
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("waiting result dropped or changed");
`endif

endmodule
`default_nettype wire

[tb/dark_level_tracker_light_detector_test.sv]
// Testbench for dark_level_tracker_light_detector: random and directed requests, a scoreboard
// that tracks the dark mean, count and threshold, and random stalls on both channels.
// Depends on dltld_pkg and the dark_level_tracker_light_detector RTL.
`timescale 1ns / 1ps

module dark_level_tracker_light_detector_test;
   import dltld_pkg::*;

   class dark_mean_scoreboard;
      logic [DATA_W-1:0]  threshold;
      logic [DATA_W-1:0]  mean;
      logic [COUNT_W-1:0] count;
      int                 group_size;
      int                 group_used;
      int                 errors;
      rsp_type            expected_rsp_q[$];

      function new(int group_size_in);
         group_size = group_size_in;
         group_used = (group_size_in < NUM_SAMPLES) ? group_size_in : NUM_SAMPLES;
         threshold  = THRESHOLD_RESET;
         mean       = '0;
         count      = '0;
         errors     = 0;
      endfunction

      function int pending();
         return expected_rsp_q.size();
      endfunction

      function void step_mean(logic [DATA_W-1:0] v);
         int n;
         int diff;
         int next_mean;
         n = (count == 0) ? 1 : int'(count);
         diff = int'(v) - int'(mean);
         next_mean = int'(mean) + diff / n;
         if (next_mean < 0) next_mean = 0;
         if (next_mean > 1023) next_mean = 1023;
         mean = next_mean[DATA_W-1:0];
         if (count != COUNT_MAX) count++;
      endfunction

      function bit is_light(logic [DATA_W-1:0] v);
         return (int'(mean) - int'(v)) > int'(threshold);
      endfunction

      function void note_request(req_type item);
         rsp_type           e;
         logic [DATA_W-1:0] s [NUM_SAMPLES];
         int                sum;
         e = '0;
         s[0] = item.sample_a;
         s[1] = item.sample_b;
         s[2] = item.sample_c;
         s[3] = item.sample_d;
         s[4] = item.sample_e;
         case (item.kind)
            KIND_SEED: begin
               mean  = s[0];
               count = 1;
            end
            KIND_UPDATE: begin
               step_mean(s[0]);
            end
            KIND_SINGLE: begin
               e.judged_value = s[0];
               e.light_seen   = is_light(s[0]);
               if (!e.light_seen) step_mean(s[0]);
            end
            KIND_GROUP, KIND_GROUP_UPD: begin
               sum = 0;
               for (int i = 0; i < group_used; i++) sum += int'(s[i]);
               e.judged_value = DATA_W'(sum / group_used);
               e.light_seen   = is_light(e.judged_value);
               if (item.kind == KIND_GROUP_UPD && !e.light_seen) begin
                  repeat (group_size) step_mean(e.judged_value);
               end
            end
            default: begin
            end
         endcase
         e.dark_mean = mean;
         expected_rsp_q.push_back(e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: result with none pending: light %0b judged %0d mean %0d",
                     $time, got.light_seen, got.judged_value, got.dark_mean);
            errors++;
            return;
         end
         e = expected_rsp_q.pop_front();
         if (got.light_seen !== e.light_seen) begin
            $display("%0t: light_seen expected %0b got %0b", $time, e.light_seen, got.light_seen);
            errors++;
         end
         if (got.judged_value !== e.judged_value) begin
            $display("%0t: judged_value expected %0d got %0d",
                     $time, e.judged_value, got.judged_value);
            errors++;
         end
         if (got.dark_mean !== e.dark_mean) begin
            $display("%0t: dark_mean expected %0d got %0d", $time, e.dark_mean, got.dark_mean);
            errors++;
         end
      endfunction
   endclass

   localparam int GROUP_SIZE     = GROUP_SIZE_DEF;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int CFG_SETTLE     = 30;
   localparam int END_SETTLE     = 150;
   localparam int NUM_PHASES     = 8;
   localparam int PHASE_ITEMS    = 160;
   localparam int CHUNK_ITEMS    = 40;
   localparam int HOLD_PHASE     = 2;

   localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;
   logic              csr_we;
   logic [DATA_W-1:0] csr_wdata;

   bit                req_idling = 1'b1;
   bit                rsp_idling = 1'b1;
   int                hold_requests = 0;
   int                stuck_cycles = 0;

   dark_mean_scoreboard sb;

   dark_level_tracker_light_detector #(.GROUP_SIZE(GROUP_SIZE)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: nothing accepted for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // result side: random stall bursts, calm stretches, and long hold-offs on request
   initial begin : rsp_driver
      int calm_left;
      int hold_served;
      calm_left = 0;
      hold_served = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (calm_left > 0) calm_left--;
         else if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 80);
         if (hold_requests != hold_served) begin
            hold_served++;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (rsp_idling && calm_left == 0 && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic logic [DATA_W-1:0] clamp10(int v);
      if (v < 0) return '0;
      if (v > 1023) return '1;
      return DATA_W'(v);
   endfunction

   function automatic req_type pack_req(logic [KIND_W-1:0] k, int a, int b = 0, int c = 0,
                                        int d = 0, int e = 0);
      req_type item;
      item.kind     = k;
      item.sample_a = clamp10(a);
      item.sample_b = clamp10(b);
      item.sample_c = clamp10(c);
      item.sample_d = clamp10(d);
      item.sample_e = clamp10(e);
      return item;
   endfunction

   task automatic send_request(input req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic sender_gap();
      if (req_idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_threshold(input int value);
      wait_drained();
      repeat (CFG_SETTLE) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= DATA_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      sb.threshold = DATA_W'(value);
   endtask

   initial begin : stimulus
      req_type           item;
      int                thr;
      int                level;
      int                base;
      int                roll;
      logic [KIND_W-1:0] k;

      sb = new(GROUP_SIZE);
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_wdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part, threshold at its reset value
      send_request(pack_req(KIND_UPDATE, 1023));   // count of zero divides by one
      send_request(pack_req(KIND_SINGLE, 0));
      send_request(pack_req(KIND_SINGLE, 1023));
      sender_gap();
      send_request(pack_req(KIND_SEED, 0));
      send_request(pack_req(KIND_UPDATE, 1023));
      send_request(pack_req(KIND_UPDATE, 0));
      send_request(pack_req(KIND_GROUP, 1023, 1023, 1023, 1023, 1023));
      send_request(pack_req(KIND_GROUP, 0, 0, 0, 0, 0));
      sender_gap();
      send_request(pack_req(KIND_GROUP_UPD, 0, 0, 0, 0, 0));
      send_request(pack_req(KIND_GROUP_UPD, 1023, 1023, 1023, 1023, 1022));
      send_request(pack_req(KIND_GROUP_UPD, 'h2AA, 'h155, 'h3FF, 0, 'h200));
      for (int s = KIND_SPARE_LO; s <= KIND_SPARE_HI; s++) begin
         send_request(pack_req(KIND_W'(s), 'h3FF, 'h155, 'h2AA, 'h3FF, 0));
      end
      send_request(pack_req(KIND_SEED, 1023));
      send_request(pack_req(KIND_SINGLE, 923));    // margin equal to threshold
      send_request(pack_req(KIND_SEED, 1023));
      send_request(pack_req(KIND_SINGLE, 922));    // one past threshold
      sender_gap();
      send_request(pack_req(KIND_SEED, 'h155));
      send_request(pack_req(KIND_SINGLE, 'h2AA));
      send_request(pack_req(KIND_GROUP, 'h155, 'h2AA, 'h155, 'h2AA, 'h155));

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: thr = 0;
            1: thr = 1023;
            2: thr = 1;
            3: thr = 512;
            default: thr = $urandom_range(0, 300);
         endcase
         write_threshold(thr);
         if (phase == NUM_PHASES - 1) rsp_idling <= 1'b0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % CHUNK_ITEMS == 0) begin
               level = $urandom_range(0, 1023);
               req_idling = (phase != NUM_PHASES - 1) && ($urandom_range(0, 2) != 0);
               if (phase == HOLD_PHASE && i == 0) begin
                  req_idling = 1'b0;
                  hold_requests <= hold_requests + 1;
               end
               send_request(pack_req(KIND_SEED, level));
               sender_gap();
            end
            case ($urandom_range(0, 3))
               0: base = $urandom_range(0, 1023);
               1: base = level + int'($urandom_range(0, 40)) - 20;
               default: base = level - thr + int'($urandom_range(0, 12)) - 6;
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 5) k = KIND_SEED;
            else if (roll < 23) k = KIND_UPDATE;
            else if (roll < 53) k = KIND_SINGLE;
            else if (roll < 65) k = KIND_GROUP;
            else if (roll < 93) k = KIND_GROUP_UPD;
            else k = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            item.kind     = k;
            item.sample_a = clamp10(base + int'($urandom_range(0, 6)) - 3);
            item.sample_b = clamp10(base + int'($urandom_range(0, 6)) - 3);
            item.sample_c = clamp10(base + int'($urandom_range(0, 6)) - 3);
            item.sample_d = clamp10(base + int'($urandom_range(0, 6)) - 3);
            item.sample_e = clamp10(base + int'($urandom_range(0, 6)) - 3);
            if ($urandom_range(0, 4) == 0) item.sample_b = DATA_W'($urandom_range(0, 1023));
            if ($urandom_range(0, 4) == 0) item.sample_d = DATA_W'($urandom_range(0, 1023));
            if (k != KIND_GROUP && k != KIND_GROUP_UPD) item.sample_a = clamp10(base);
            send_request(item);
            sender_gap();
         end
      end

      wait_drained();
      repeat (END_SETTLE) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
